// ----- hw/rtl/obbat_pkg.sv -----
package obbat_pkg;

  // Internal precision of the sine series used to build the angle tables.
  localparam int unsigned QW = 30;
  // Quarter turn in QW fraction bits.
  localparam longint unsigned HALF_PI_Q = 64'd1686629713;

  // Corner sign patterns, bit i set when that corner's offset is negative.
  localparam logic [3:0] CORNER_SX_NEG = 4'b1001;
  localparam logic [3:0] CORNER_SY_NEG = 4'b0011;

  // Factorial step divisors of the sine (odd) and cosine (even) series terms.
  localparam longint unsigned SERIES_DIV_ODD [9] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272, 64'd342
  };
  localparam longint unsigned SERIES_DIV_EVEN [9] = '{
    64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132, 64'd182, 64'd240, 64'd306
  };

  // Taylor series for sine (odd) or cosine (even) of t in QW fraction bits,
  // 0 <= t < pi/2. Used only while the tables are built at elaboration.
  function automatic longint series(longint unsigned t, bit odd);
    longint unsigned t2;
    longint unsigned term;
    longint          sum;
    t2 = (t * t) >> QW;
    term = odd ? t : (64'd1 << QW);
    sum = longint'(term);
    for (int k = 1; k <= 9; k++) begin
      term = (term * t2) >> QW;
      if (odd) term = term / SERIES_DIV_ODD[k-1];
      else term = term / SERIES_DIV_EVEN[k-1];
      if ((k & 1) == 1) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    if (sum > (64'sd1 <<< QW)) sum = 64'sd1 <<< QW;
    return sum;
  endfunction

endpackage

// ----- hw/rtl/obbat_range.sv -----
// Minimum and maximum of four projected corner values.
module obbat_range #(
  parameter int W = 31
) (
  input  logic signed [W-1:0] p [4],
  output logic signed [W-1:0] lo,
  output logic signed [W-1:0] hi
);

  logic signed [W-1:0] lo_a, lo_b, hi_a, hi_b;

  // Pairwise compare, then a final compare of the two pairs.
  always_comb begin
    lo_a = (p[1] < p[0]) ? p[1] : p[0];
    hi_a = (p[1] > p[0]) ? p[1] : p[0];
    lo_b = (p[3] < p[2]) ? p[3] : p[2];
    hi_b = (p[3] > p[2]) ? p[3] : p[2];
    lo   = (lo_b < lo_a) ? lo_b : lo_a;
    hi   = (hi_b > hi_a) ? hi_b : hi_a;
  end

endmodule

// ----- hw/rtl/obb_aabb_overlap_test_unit.sv -----
// Channel   | Ports                                              | Handshake
// ----------+----------------------------------------------------+-------------------------
// request   | obb_x obb_y obb_half_w obb_half_h obb_angle        | start high, busy low
//           | box_x box_y box_half_w box_half_h                  |
// result    | hit                                                | done high for one cycle
//
// One transaction enters per cycle; busy is never raised.
// The result strobe rises together with the registered hit, after the register
// stages for angle table read, rotation products, corner sums, box-axis
// projections, range min/max, and the overlap compare, one register stage each.
// Synchronous reset clears the valid bits; data registers are not reset.
// The receiver cannot stall, so the pipeline never holds.
module obb_aabb_overlap_test_unit #(
  parameter int FRAC_BITS   = 10,
  parameter int ANGLE_STEPS = 360
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] obb_x,
  input  logic signed [15:0] obb_y,
  input  logic        [14:0] obb_half_w,
  input  logic        [14:0] obb_half_h,
  input  logic        [8:0]  obb_angle,
  input  logic signed [15:0] box_x,
  input  logic signed [15:0] box_y,
  input  logic        [14:0] box_half_w,
  input  logic        [14:0] box_half_h,
  output logic               hit,
  output logic               done
);

  localparam int CW        = FRAC_BITS + 2;      // sine and cosine
  localparam int VW        = FRAC_BITS + 18;     // corner coordinates
  localparam int PW        = 2 * FRAC_BITS + 21; // dot products
  localparam int RW        = FRAC_BITS + 21;     // projections
  localparam int ANG_DEPTH = 512;

  // Rounded sine of num quarter-steps, built at elaboration.
  function automatic longint table_sin(longint num);
    longint n4, q, r, t, mag, rnd;
    n4 = num % (4 * ANGLE_STEPS);
    q = n4 / ANGLE_STEPS;
    r = n4 % ANGLE_STEPS;
    t = longint'((obbat_pkg::HALF_PI_Q * longint'(r)) / ANGLE_STEPS);
    mag = obbat_pkg::series(t, (q % 2) == 0);
    rnd = (mag + (64'sd1 <<< (obbat_pkg::QW - FRAC_BITS - 1)))
          >>> (obbat_pkg::QW - FRAC_BITS);
    return (q >= 2) ? -rnd : rnd;
  endfunction

  // Angle tables covering every code of the angle field.
  logic signed [CW-1:0] sin_tab [ANG_DEPTH];
  logic signed [CW-1:0] cos_tab [ANG_DEPTH];
  for (genvar k = 0; k < ANG_DEPTH; k++) begin : g_tab
    localparam longint SV = table_sin(4 * (k % ANGLE_STEPS));
    localparam longint CV = table_sin(4 * (k % ANGLE_STEPS) + ANGLE_STEPS);
    assign sin_tab[k] = SV[CW-1:0];
    assign cos_tab[k] = CV[CW-1:0];
  end

  assign busy = 1'b0;

  logic v1, v2, v3, v4, v5;

  // Stage 1: table read and input capture.
  logic signed [CW-1:0] s1_sin, s1_cos;
  logic signed [15:0]   s1_ox, s1_oy, s1_bx, s1_by;
  logic        [14:0]   s1_hw, s1_hh, s1_bw, s1_bh;

  always_ff @(posedge clk) begin
    s1_sin <= sin_tab[obb_angle];
    s1_cos <= cos_tab[obb_angle];
    s1_ox  <= obb_x;
    s1_oy  <= obb_y;
    s1_hw  <= obb_half_w;
    s1_hh  <= obb_half_h;
    s1_bx  <= box_x;
    s1_by  <= box_y;
    s1_bw  <= box_half_w;
    s1_bh  <= box_half_h;
  end

  // Stage 2: rotated half extents and scaled centers.
  logic signed [VW-1:0] s2_hwc, s2_hws, s2_hhc, s2_hhs;
  logic signed [VW-1:0] s2_ox, s2_oy, s2_bx, s2_by, s2_bw, s2_bh;
  logic signed [CW-1:0] s2_sin, s2_cos;

  always_ff @(posedge clk) begin
    s2_hwc <= VW'($signed({1'b0, s1_hw})) * VW'(s1_cos);
    s2_hws <= VW'($signed({1'b0, s1_hw})) * VW'(s1_sin);
    s2_hhc <= VW'($signed({1'b0, s1_hh})) * VW'(s1_cos);
    s2_hhs <= VW'($signed({1'b0, s1_hh})) * VW'(s1_sin);
    s2_ox  <= VW'($signed({s1_ox, {FRAC_BITS{1'b0}}}));
    s2_oy  <= VW'($signed({s1_oy, {FRAC_BITS{1'b0}}}));
    s2_bx  <= VW'($signed({s1_bx, {FRAC_BITS{1'b0}}}));
    s2_by  <= VW'($signed({s1_by, {FRAC_BITS{1'b0}}}));
    s2_bw  <= VW'($signed({1'b0, s1_bw, {FRAC_BITS{1'b0}}}));
    s2_bh  <= VW'($signed({1'b0, s1_bh, {FRAC_BITS{1'b0}}}));
    s2_sin <= s1_sin;
    s2_cos <= s1_cos;
  end

  // Stage 3: corners of both boxes.
  logic signed [VW-1:0] ovx_next [4], ovy_next [4], bvx_next [4], bvy_next [4];
  logic signed [VW-1:0] s3_ovx [4], s3_ovy [4], s3_bvx [4], s3_bvy [4];
  logic signed [CW-1:0] s3_sin, s3_cos;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (obbat_pkg::CORNER_SX_NEG[i]) begin
        ovx_next[i] = s2_ox - s2_hwc;
        ovy_next[i] = s2_oy - s2_hws;
        bvx_next[i] = s2_bx - s2_bw;
      end else begin
        ovx_next[i] = s2_ox + s2_hwc;
        ovy_next[i] = s2_oy + s2_hws;
        bvx_next[i] = s2_bx + s2_bw;
      end
      if (obbat_pkg::CORNER_SY_NEG[i]) begin
        ovx_next[i] = ovx_next[i] + s2_hhs;
        ovy_next[i] = ovy_next[i] - s2_hhc;
        bvy_next[i] = s2_by - s2_bh;
      end else begin
        ovx_next[i] = ovx_next[i] - s2_hhs;
        ovy_next[i] = ovy_next[i] + s2_hhc;
        bvy_next[i] = s2_by + s2_bh;
      end
    end
  end

  always_ff @(posedge clk) begin
    s3_ovx <= ovx_next;
    s3_ovy <= ovy_next;
    s3_bvx <= bvx_next;
    s3_bvy <= bvy_next;
    s3_sin <= s2_sin;
    s3_cos <= s2_cos;
  end

  // Stage 4: projections on the four axes; index [axis][box][corner].
  logic signed [RW-1:0] proj_next [4][2][4];
  logic signed [RW-1:0] s4_proj [4][2][4];
  logic signed [VW-1:0] cx, cy;
  logic signed [PW-1:0] dot_u, dot_v;

  always_comb begin
    cx = '0;
    cy = '0;
    dot_u = '0;
    dot_v = '0;
    for (int b = 0; b < 2; b++) begin
      for (int i = 0; i < 4; i++) begin
        cx = (b == 0) ? s3_ovx[i] : s3_bvx[i];
        cy = (b == 0) ? s3_ovy[i] : s3_bvy[i];
        dot_u = PW'(cx) * PW'(s3_cos) + PW'(cy) * PW'(s3_sin);
        dot_v = PW'(cy) * PW'(s3_cos) - PW'(cx) * PW'(s3_sin);
        proj_next[0][b][i] = RW'(cx);
        proj_next[1][b][i] = RW'(cy);
        proj_next[2][b][i] = RW'(dot_u >>> FRAC_BITS);
        proj_next[3][b][i] = RW'(dot_v >>> FRAC_BITS);
      end
    end
  end

  always_ff @(posedge clk) begin
    s4_proj <= proj_next;
  end

  // Stage 5: projected ranges of each box on each axis.
  logic signed [RW-1:0] lo_next [4][2], hi_next [4][2];
  logic signed [RW-1:0] s5_lo [4][2], s5_hi [4][2];

  for (genvar a = 0; a < 4; a++) begin : g_axis
    for (genvar b = 0; b < 2; b++) begin : g_box
      obbat_range #(.W(RW)) u_range (
        .p  (s4_proj[a][b]),
        .lo (lo_next[a][b]),
        .hi (hi_next[a][b])
      );
    end
  end

  always_ff @(posedge clk) begin
    s5_lo <= lo_next;
    s5_hi <= hi_next;
  end

  // Stage 6: the boxes overlap when no axis separates them.
  logic [3:0] axis_ok;

  always_comb begin
    for (int a = 0; a < 4; a++) begin
      axis_ok[a] = !((s5_hi[a][0] < s5_lo[a][1]) || (s5_hi[a][1] < s5_lo[a][0]));
    end
  end

  always_ff @(posedge clk) begin
    hit <= &axis_ok;
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      v4   <= 1'b0;
      v5   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= start && !busy;
      v2   <= v1;
      v3   <= v2;
      v4   <= v3;
      v5   <= v4;
      done <= v5;
    end
  end

  // A transaction taken in always gives its result strobe.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##6 done)
    else $error("result missing six cycles after accept");

  // A result comes only from a valid last stage.
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !v5 |=> !done)
    else $error("result strobe without a valid item");

  // A reported hit means every axis overlapped in the cycle before.
  a_hit_axes: assert property (@(posedge clk) disable iff (rst)
    (done && hit) |-> $past(axis_ok == 4'hF))
    else $error("hit reported with a separating axis");

endmodule
